### hdl/lavm_pkg.sv
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared types, constants and helpers of the look-at view matrix unit.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int EXT_W = (COORD_WIDTH > 33) ? COORD_WIDTH : 33;

  localparam logic signed [EXT_W-1:0] CRD_MAX = EXT_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [EXT_W-1:0] CRD_MIN = EXT_W'(-64'sh0000_0000_8000_0000);

  typedef logic signed [COORD_WIDTH-1:0] raw_t;
  typedef logic signed [31:0] crd_t;
  typedef logic signed [32:0] dif_t;
  typedef logic signed [63:0] wide_t;
  typedef crd_t [2:0] cvec_t;
  typedef dif_t [2:0] dvec_t;
  typedef wide_t [2:0] wvec_t;

  typedef struct packed {
    raw_t eye_x;
    raw_t eye_y;
    raw_t eye_z;
    raw_t target_x;
    raw_t target_y;
    raw_t target_z;
    raw_t upward_x;
    raw_t upward_y;
    raw_t upward_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0] row_number;
    crd_t       entry_a;
    crd_t       entry_b;
    crd_t       entry_c;
    crd_t       shift_term;
    logic       final_row;
  } out_item_t;

  typedef struct packed {
    cvec_t eye;
    cvec_t up;
    dvec_t fwd;
  } job_t;

  typedef struct packed {
    logic  start;
    wvec_t vec;
  } ureq_t;

  typedef struct packed {
    logic  done;
    cvec_t q;
  } ursp_t;

  localparam logic [1:0] ROW_SIDE = 2'd0;
  localparam logic [1:0] ROW_UP   = 2'd1;
  localparam logic [1:0] ROW_FWD  = 2'd2;

  function automatic crd_t take_coord(input raw_t raw);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(raw);
    if (e > CRD_MAX) return crd_t'(CRD_MAX[31:0]);
    if (e < CRD_MIN) return crd_t'(CRD_MIN[31:0]);
    return e[31:0];
  endfunction

  function automatic crd_t pick(input cvec_t v, input logic [1:0] i);
    case (i)
      2'd0:    return v[0];
      2'd1:    return v[1];
      2'd2:    return v[2];
      default: return '0;
    endcase
  endfunction

endpackage

### hdl/lavm_front.sv
// ----------------------------------------------------------------------------
// lavm_front
// Accepts items, clamps coordinates, forms the forward vector and queues jobs.
// ----------------------------------------------------------------------------
module lavm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lavm_pkg::in_item_t in_item,
  output logic              job_valid,
  output lavm_pkg::job_t    job,
  input  logic              job_pop
);
  import lavm_pkg::*;

  job_t       q_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  job_t       conv;
  logic       push, pop;

  always_comb begin
    conv.eye[0] = take_coord(in_item.eye_x);
    conv.eye[1] = take_coord(in_item.eye_y);
    conv.eye[2] = take_coord(in_item.eye_z);
    conv.up[0]  = take_coord(in_item.upward_x);
    conv.up[1]  = take_coord(in_item.upward_y);
    conv.up[2]  = take_coord(in_item.upward_z);
    conv.fwd[0] = 33'(conv.eye[0]) - 33'(take_coord(in_item.target_x));
    conv.fwd[1] = 33'(conv.eye[1]) - 33'(take_coord(in_item.target_y));
    conv.fwd[2] = 33'(conv.eye[2]) - 33'(take_coord(in_item.target_z));
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign job_valid = (cnt_r != 2'd0);
  assign pop       = job_pop && job_valid;
  assign job       = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= conv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### hdl/lavm_unit.sv
// ----------------------------------------------------------------------------
// lavm_unit
// Scales one vector to unit length: normalize, square, square root, divide.
// ----------------------------------------------------------------------------
module lavm_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  lavm_pkg::ureq_t req,
  output lavm_pkg::ursp_t rsp
);
  import lavm_pkg::*;

  typedef enum logic [5:0] {
    U_IDLE = 6'b000001,
    U_NORM = 6'b000010,
    U_SQ   = 6'b000100,
    U_SQRT = 6'b001000,
    U_DIV  = 6'b010000,
    U_DONE = 6'b100000
  } ustate_t;

  localparam logic [62:0] ONE_Q30  = 63'd1 << 30;
  localparam logic [62:0] HALF_Q30 = 63'd1 << 29;

  ustate_t     state_r;
  logic        neg_r [3];
  logic [62:0] mag_r [3];
  logic [62:0] m_r;
  logic [1:0]  k_r;
  logic [61:0] sum_r;
  logic [63:0] sv_r, res_r, bit_r;
  logic [61:0] d_r;
  logic [61:0] rem_r [3];
  logic [30:0] qd_r [3];
  logic [4:0]  cnt_r;
  cvec_t       q_r;

  logic [62:0] a [3];
  logic [63:0] nv [3];
  logic [62:0] mx;
  logic [29:0] msel;
  logic [59:0] sq;
  logic [61:0] sum_nxt;
  logic [63:0] trial, sv_nxt, res_nxt;
  logic        ge [3];
  logic [30:0] qd_nxt [3];
  logic signed [31:0] qv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i] = 64'd0 - req.vec[i];
      a[i]  = req.vec[i][63] ? nv[i][62:0] : req.vec[i][62:0];
    end
    mx = a[0];
    if (a[1] > mx) mx = a[1];
    if (a[2] > mx) mx = a[2];
    msel    = mag_r[k_r][29:0];
    sq      = msel * msel;
    sum_nxt = sum_r + 62'(sq);
    trial   = res_r + bit_r;
    if (sv_r >= trial) begin
      sv_nxt  = sv_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      sv_nxt  = sv_r;
      res_nxt = res_r >> 1;
    end
    for (int i = 0; i < 3; i++) begin
      ge[i]     = rem_r[i] >= d_r;
      qd_nxt[i] = {qd_r[i][29:0], ge[i]};
      qv[i]     = {1'b0, qd_nxt[i]};
    end
  end

  assign rsp.done = (state_r == U_DONE);
  assign rsp.q    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      case (state_r)
        U_IDLE: begin
          if (req.start) begin
            for (int i = 0; i < 3; i++) begin
              neg_r[i] <= req.vec[i][63];
              mag_r[i] <= a[i];
              q_r[i]   <= '0;
            end
            m_r     <= mx;
            state_r <= (mx == '0) ? U_DONE : U_NORM;
          end
        end
        U_NORM: begin
          if (m_r >= ONE_Q30) begin
            m_r <= m_r >> 1;
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else if (m_r < HALF_Q30) begin
            m_r <= m_r << 1;
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
          end else begin
            k_r     <= 2'd0;
            sum_r   <= '0;
            state_r <= U_SQ;
          end
        end
        U_SQ: begin
          sum_r <= sum_nxt;
          k_r   <= k_r + 2'd1;
          if (k_r == 2'd2) begin
            sv_r    <= 64'(sum_nxt);
            res_r   <= '0;
            bit_r   <= 64'd1 << 62;
            state_r <= U_SQRT;
          end
        end
        U_SQRT: begin
          sv_r  <= sv_nxt;
          res_r <= res_nxt;
          bit_r <= bit_r >> 2;
          if (bit_r == 64'd1) begin
            d_r <= 62'(res_nxt) << 30;
            for (int i = 0; i < 3; i++) begin
              rem_r[i] <= (62'(mag_r[i][29:0]) << 30) + 62'(res_nxt >> 1);
              qd_r[i]  <= '0;
            end
            cnt_r   <= 5'd30;
            state_r <= U_DIV;
          end
        end
        U_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (ge[i]) rem_r[i] <= rem_r[i] - d_r;
            qd_r[i] <= qd_nxt[i];
            q_r[i]  <= neg_r[i] ? -qv[i] : qv[i];
          end
          d_r   <= d_r >> 1;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) state_r <= U_DONE;
        end
        U_DONE:  state_r <= U_IDLE;
        default: state_r <= U_IDLE;
      endcase
    end
  end

endmodule

### hdl/lavm_back.sv
// ----------------------------------------------------------------------------
// lavm_back
// Sequences the axes, cross and dot products and drives the result register.
// ----------------------------------------------------------------------------
module lavm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  lavm_pkg::job_t     job,
  output logic               job_pop,
  output lavm_pkg::ureq_t    ureq,
  input  lavm_pkg::ursp_t    ursp,
  output logic               out_valid,
  input  logic               out_stall,
  output lavm_pkg::out_item_t out_item
);
  import lavm_pkg::*;

  typedef enum logic [7:0] {
    B_IDLE = 8'b00000001,
    B_Z    = 8'b00000010,
    B_CX1  = 8'b00000100,
    B_X    = 8'b00001000,
    B_CX2  = 8'b00010000,
    B_Y    = 8'b00100000,
    B_DOT  = 8'b01000000,
    B_OUT  = 8'b10000000
  } bstate_t;

  bstate_t   state_r;
  cvec_t     eye_r, up_r, r0_r, r1_r, r2_r;
  wvec_t     tmp_r;
  logic [2:0] k_r;
  logic [1:0] row_r;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r;
  out_item_t out_r;
  logic      out_valid_r;

  cvec_t      av, bv, row_sel;
  logic [1:0] ai, bi, comp;
  logic [2:0] tk;
  crd_t       a_op, b_op;
  logic signed [65:0] v;
  logic signed [35:0] f;
  crd_t       sh;
  logic       load;
  wvec_t      fwd_w;

  always_comb begin
    case (row_r)
      ROW_SIDE: row_sel = r0_r;
      ROW_UP:   row_sel = r1_r;
      default:  row_sel = r2_r;
    endcase
    case (k_r)
      3'd0:    begin ai = 2'd1; bi = 2'd2; end
      3'd1:    begin ai = 2'd2; bi = 2'd1; end
      3'd2:    begin ai = 2'd2; bi = 2'd0; end
      3'd3:    begin ai = 2'd0; bi = 2'd2; end
      3'd4:    begin ai = 2'd0; bi = 2'd1; end
      3'd5:    begin ai = 2'd1; bi = 2'd0; end
      default: begin ai = 2'd3; bi = 2'd3; end
    endcase
    av = up_r;
    bv = r2_r;
    case (state_r)
      B_CX2: begin
        av = r2_r;
        bv = r0_r;
      end
      B_DOT: begin
        av = row_sel;
        bv = eye_r;
        ai = k_r[1:0];
        bi = k_r[1:0];
      end
      default: ;
    endcase
    a_op = pick(av, ai);
    b_op = pick(bv, bi);
    tk   = k_r - 3'd1;
    comp = tk[2:1];
    v    = 66'sh0_2000_0000 - acc_r;
    f    = v[65:30];
    if (f > 36'sh0_7FFF_FFFF)       sh = 32'sh7FFF_FFFF;
    else if (f < -36'sh0_8000_0000) sh = -32'sh8000_0000;
    else                            sh = f[31:0];
    for (int i = 0; i < 3; i++) fwd_w[i] = 64'(job.fwd[i]);
  end

  assign load      = (state_r == B_OUT) && (!out_valid_r || !out_stall);
  assign job_pop   = (state_r == B_IDLE) && job_valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    ureq.start = 1'b0;
    ureq.vec   = tmp_r;
    case (state_r)
      B_IDLE: begin
        ureq.start = job_valid;
        ureq.vec   = fwd_w;
      end
      B_CX1, B_CX2: ureq.start = (k_r == 3'd7);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= a_op * b_op;
    if ((state_r == B_CX1 || state_r == B_CX2) && k_r != 3'd0 && k_r != 3'd7) begin
      if (!tk[0]) tmp_r[comp] <= prod_r;
      else        tmp_r[comp] <= tmp_r[comp] - prod_r;
    end
    if (state_r == B_DOT && k_r != 3'd0) begin
      acc_r <= (k_r == 3'd1) ? 66'(prod_r) : acc_r + 66'(prod_r);
    end
    if (job_pop) begin
      eye_r <= job.eye;
      up_r  <= job.up;
    end
    if (state_r == B_Z && ursp.done) r2_r <= ursp.q;
    if (state_r == B_X && ursp.done) r0_r <= ursp.q;
    if (state_r == B_Y && ursp.done) r1_r <= ursp.q;
    if (load) begin
      out_r.row_number <= row_r;
      out_r.entry_a    <= row_sel[0];
      out_r.entry_b    <= row_sel[1];
      out_r.entry_c    <= row_sel[2];
      out_r.shift_term <= sh;
      out_r.final_row  <= (row_r == ROW_FWD);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      row_r       <= ROW_SIDE;
    end else begin
      if (load)                        out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: if (job_valid) state_r <= B_Z;
        B_Z: begin
          if (ursp.done) begin
            k_r     <= '0;
            state_r <= B_CX1;
          end
        end
        B_CX1: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd7) state_r <= B_X;
        end
        B_X: begin
          if (ursp.done) begin
            k_r     <= '0;
            state_r <= B_CX2;
          end
        end
        B_CX2: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd7) state_r <= B_Y;
        end
        B_Y: begin
          if (ursp.done) begin
            k_r     <= '0;
            row_r   <= ROW_SIDE;
            state_r <= B_DOT;
          end
        end
        B_DOT: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd3) state_r <= B_OUT;
        end
        B_OUT: begin
          if (load) begin
            k_r <= '0;
            if (row_r == ROW_FWD) begin
              state_r <= B_IDLE;
            end else begin
              row_r   <= row_r + 2'd1;
              state_r <= B_DOT;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

### hdl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// The first row of an item comes soonest when every axis is zero, since the
// unit-length unit then skips its steps; the other two rows follow in turn.
// The shared unit-length unit (1-bit normalize steps, 32-step square root,
// 31-step divide) runs three times per item and sets the item rate; the back
// end works on one job at a time, and a two-entry job queue lets items be
// taken while the back end works. Reset clears control state only.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lavm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lavm_pkg::out_item_t out_item
);
  import lavm_pkg::*;

  logic  job_valid, job_pop;
  job_t  job;
  ureq_t ureq;
  ursp_t ursp;

  lavm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  lavm_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ureq),
    .rsp   (ursp)
  );

  lavm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .ureq      (ureq),
    .ursp      (ursp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the look-at view matrix unit: drives camera items
// with random gaps, long output stalls and a drain pause, predicts the three
// rows of each item and compares every result field by field in order.
// ----------------------------------------------------------------------------
class row_scoreboard;
  lavm_pkg::out_item_t rows_due[$];
  int mismatches;
  int rows_checked;

  static function longint clamp_coord(lavm_pkg::raw_t raw);
    longint v;
    v = longint'(raw);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  static function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  static function void to_unit(input longint v[3], output longint q[3]);
    logic [63:0] mag[3];
    logic [127:0] num;
    logic [63:0] m, sum, len;
    bit neg[3];
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      q[0] = 0; q[1] = 0; q[2] = 0;
      return;
    end
    while (m >= (64'd1 << 30)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      num = ({64'd0, mag[i]} << 30) + (len >> 1);
      num = num / len;
      q[i] = neg[i] ? -longint'(num[63:0]) : longint'(num[63:0]);
    end
  endfunction

  static function void cross_prod(input longint a[3], input longint b[3],
                                  output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  static function logic [31:0] translation(longint row[3], longint eye[3]);
    longint v, f;
    v = -(row[0] * eye[0] + row[1] * eye[1] + row[2] * eye[2]) + (64'sd1 <<< 29);
    f = v >>> 30;
    if (f > 64'sd2147483647) f = 64'sd2147483647;
    if (f < -64'sd2147483648) f = -64'sd2147483648;
    return f[31:0];
  endfunction

  function void note_camera(lavm_pkg::in_item_t it);
    longint eye[3], tgt[3], up[3], fwd[3], tmp[3];
    longint axis[3][3];
    lavm_pkg::out_item_t r;
    eye[0] = clamp_coord(it.eye_x);
    eye[1] = clamp_coord(it.eye_y);
    eye[2] = clamp_coord(it.eye_z);
    tgt[0] = clamp_coord(it.target_x);
    tgt[1] = clamp_coord(it.target_y);
    tgt[2] = clamp_coord(it.target_z);
    up[0] = clamp_coord(it.upward_x);
    up[1] = clamp_coord(it.upward_y);
    up[2] = clamp_coord(it.upward_z);
    for (int i = 0; i < 3; i++) fwd[i] = eye[i] - tgt[i];
    to_unit(fwd, axis[2]);
    cross_prod(up, axis[2], tmp);
    to_unit(tmp, axis[0]);
    cross_prod(axis[2], axis[0], tmp);
    to_unit(tmp, axis[1]);
    for (int k = 0; k < 3; k++) begin
      r.row_number = k[1:0];
      r.entry_a = axis[k][0][31:0];
      r.entry_b = axis[k][1][31:0];
      r.entry_c = axis[k][2][31:0];
      r.shift_term = translation(axis[k], eye);
      r.final_row = (k[1:0] == lavm_pkg::ROW_FWD);
      rows_due.push_back(r);
    end
  endfunction

  function void check_row(lavm_pkg::out_item_t got);
    lavm_pkg::out_item_t want;
    rows_checked++;
    if (rows_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected row: %p", got);
      return;
    end
    want = rows_due.pop_front();
    if (got.row_number !== want.row_number || got.entry_a !== want.entry_a ||
        got.entry_b !== want.entry_b || got.entry_c !== want.entry_c ||
        got.shift_term !== want.shift_term || got.final_row !== want.final_row) begin
      mismatches++;
      if (mismatches <= 10) $display("row mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module tb;
  import lavm_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;

  row_scoreboard board;
  bit hold_rows;
  int cameras_sent;

  look_at_view_matrix uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic raw_t edge_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 0;
      3: return 32'sh0001_0000;
      4: return 32'shFFFF_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic raw_t scene_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return edge_coord();
      2, 3: return raw_t'($urandom_range(0, 32'h1F)) - 16;
      default: return raw_t'(int'($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
    endcase
  endfunction

  task automatic send_camera(in_item_t it);
    int gap;
    gap = $urandom_range(0, 6);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_camera(it);
    cameras_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_all(raw_t e[3], raw_t t[3], raw_t u[3]);
    in_item_t it;
    it = '{e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]};
    send_camera(it);
  endtask

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) board.check_row(out_item);

  initial begin
    int pause;
    pause = $urandom_range(0, 6);
    forever begin
      @(negedge clk);
      if (hold_rows || pause != 0) begin
        out_stall <= 1'b1;
        if (!hold_rows) pause--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
      if (out_valid && !out_stall) pause = $urandom_range(0, 6);
    end
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    raw_t e[3], t[3], u[3];
    int waited;
    board = new();
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    in_item = '0;
    hold_rows = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    e = '{0, 0, 32'sh0005_0000}; t = '{0, 0, 0}; u = '{0, 32'sh0001_0000, 0};
    send_all(e, t, u);
    e = '{32'sh0001_0000, 0, 0}; t = e;
    send_all(e, t, u);
    e = '{0, 32'sh0003_0000, 0}; t = '{0, 0, 0};
    send_all(e, t, u);
    e = '{0, 0, 32'sh0002_0000}; u = '{0, 0, 0};
    send_all(e, t, u);
    e = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    t = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    u = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
    send_all(e, t, u);
    send_all(t, e, '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
    send_all('{32'sh8000_0000, 0, 32'sh7FFF_FFFF}, '{0, 32'sh7FFF_FFFF, 0},
             '{1, -1, 1});
    send_all('{1, 0, 0}, '{0, 0, 0}, '{0, 1, 0});
    send_all('{-1, -1, -1}, '{0, 0, 0}, '{-1, 0, 0});
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 3; k++) begin
        e[k] = edge_coord(); t[k] = edge_coord(); u[k] = edge_coord();
      end
      send_all(e, t, u);
    end

    hold_rows = 1;
    fork
      begin
        waited = 0;
        while (waited < 1500) begin
          @(posedge clk);
          waited++;
        end
        hold_rows = 0;
      end
      begin
        for (int i = 0; i < 6; i++) begin
          for (int k = 0; k < 3; k++) begin
            e[k] = scene_coord(); t[k] = scene_coord(); u[k] = scene_coord();
          end
          send_all(e, t, u);
        end
        stop_sending();
      end
    join

    while (board.rows_due.size() != 0) @(posedge clk);

    for (int i = 0; i < 125; i++) begin
      for (int k = 0; k < 3; k++) begin
        e[k] = scene_coord(); t[k] = scene_coord(); u[k] = scene_coord();
      end
      if ($urandom_range(0, 7) == 0) u = '{$urandom, $urandom, $urandom};
      if ($urandom_range(0, 15) == 0) t = e;
      send_all(e, t, u);
    end
    stop_sending();

    while (board.rows_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Covered %0d camera items, %0d rows checked, including degenerate and",
             cameras_sent, board.rows_checked);
    $display("full-range inputs, a long output stall and a drained pause.");
    if (board.mismatches == 0 && board.rows_due.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
